[hdl/glb_pkg.sv]
// Package for the gradient color table builder: sizes, command and status
// structs, and the controller state type. No dependencies.
`default_nettype none

package glb_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int CHANNELS    = 4;

  localparam int NUM_CH  = 4;
  localparam int CH_W    = 8;
  localparam int POS_W   = 17;
  localparam int RDIDX_W = 8;
  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int RD_W    = (IDX_W + 1 > RDIDX_W) ? IDX_W + 1 : RDIDX_W + 1;
  localparam int PROD_W  = POS_W + IDX_W;

  localparam logic [POS_W-1:0] POS_ONE  = POS_W'(65536);
  localparam logic [POS_W-1:0] POS_HALF = POS_W'(32768);

  // One quotient bit per step of the restoring divider.
  localparam int DIV_STEPS = CH_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef logic [NUM_CH-1:0][CH_W-1:0] color_t;

  typedef enum logic [1:0] {
    SEG_HEAD,
    SEG_RAMP,
    SEG_TAIL
  } seg_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INDEX,
    ST_PLAN,
    ST_DIV,
    ST_WALK_SEG,
    ST_TAIL_SET,
    ST_WALK_TAIL,
    ST_COMMIT,
    ST_READ
  } ctrl_state_e;

  typedef struct packed {
    logic      ld_latch;
    logic      rd_issue;
    logic      calc_idx;
    logic      setup;
    seg_kind_e seg_kind;
    logic      div_step;
    logic      walk_step;
    logic      commit;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic last;
    logic backward;
    logic seg_zero;
    logic div_done;
    logic walk_done;
    logic out_full;
  } dp_status_t;

endpackage

`default_nettype wire

[hdl/glb_ctrl.sv]
// Controller of the gradient color table builder: sequences index mapping,
// segment division and table walks. Depends on glb_pkg.
`default_nettype none

module glb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                func_i,
  output logic                in_ready_o,
  input  glb_pkg::dp_status_t status_i,
  output glb_pkg::dp_cmd_t    cmd_o
);
  import glb_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (func_i == FUNC_READ) ? ST_READ : ST_INDEX;
        end
      end
      ST_INDEX: state_d = ST_PLAN;
      ST_PLAN: begin
        if (!status_i.have_prev) begin
          state_d = ST_WALK_SEG;
        end else if (status_i.backward) begin
          state_d = status_i.last ? ST_TAIL_SET : ST_COMMIT;
        end else if (status_i.seg_zero) begin
          state_d = ST_WALK_SEG;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_WALK_SEG;
        end
      end
      ST_WALK_SEG: begin
        if (status_i.walk_done) begin
          state_d = status_i.last ? ST_TAIL_SET : ST_COMMIT;
        end
      end
      ST_TAIL_SET: state_d = ST_WALK_TAIL;
      ST_WALK_TAIL: begin
        if (status_i.walk_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: state_d = ST_IDLE;
      ST_READ: begin
        if (!status_i.out_full) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.ld_latch = in_valid_i && (func_i == FUNC_LOAD);
        cmd_o.rd_issue = in_valid_i && (func_i == FUNC_READ);
      end
      ST_INDEX: cmd_o.calc_idx = 1'b1;
      ST_PLAN: begin
        if (!status_i.have_prev) begin
          cmd_o.setup    = 1'b1;
          cmd_o.seg_kind = SEG_HEAD;
        end else if (!status_i.backward) begin
          cmd_o.setup    = 1'b1;
          cmd_o.seg_kind = SEG_RAMP;
        end
      end
      ST_DIV:       cmd_o.div_step  = 1'b1;
      ST_WALK_SEG:  cmd_o.walk_step = 1'b1;
      ST_TAIL_SET: begin
        cmd_o.setup    = 1'b1;
        cmd_o.seg_kind = SEG_TAIL;
      end
      ST_WALK_TAIL: cmd_o.walk_step = 1'b1;
      ST_COMMIT:    cmd_o.commit    = 1'b1;
      ST_READ:      cmd_o.out_load  = !status_i.out_full;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/glb_dpath.sv]
// Datapath of the gradient color table builder: index mapping, per-channel
// slope dividers, the incremental table walker, the table and the output
// register. Depends on glb_pkg.
`default_nettype none

module glb_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  glb_pkg::dp_cmd_t            cmd_i,
  output glb_pkg::dp_status_t         status_o,
  input  logic [glb_pkg::POS_W-1:0]   position_i,
  input  logic [glb_pkg::CH_W-1:0]    red_in_i,
  input  logic [glb_pkg::CH_W-1:0]    green_in_i,
  input  logic [glb_pkg::CH_W-1:0]    blue_in_i,
  input  logic [glb_pkg::CH_W-1:0]    alpha_in_i,
  input  logic                        last_stop_i,
  input  logic [glb_pkg::RDIDX_W-1:0] read_index_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output glb_pkg::color_t             out_color_o
);
  import glb_pkg::*;

  logic [POS_W-1:0]  pos_q;
  color_t            color_q, prev_color_q, color_in;
  logic              last_q, have_prev_q;
  logic [IDX_W-1:0]  idx_q, idx_d, prev_idx_q;
  logic [IDX_W-1:0]  walk_addr_q, walk_end_q, seg_d_q;
  logic              seg_ramp_q;
  logic [POS_W-1:0]  pos_sat;
  logic [PROD_W-1:0] prod, idx_sum;

  color_t            q_q, q_d, quo_q, quo_d, quo_init, dq_w;
  logic [IDX_W-1:0]  r_q [NUM_CH];
  logic [IDX_W-1:0]  r_d [NUM_CH];
  logic [IDX_W-1:0]  rem_q [NUM_CH];
  logic [IDX_W-1:0]  rem_d [NUM_CH];
  logic [IDX_W-1:0]  dr_w [NUM_CH];
  logic [NUM_CH-1:0] neg_q, neg_init;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic              rem_ok;

  color_t            table_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_q;
  color_t            rd_data_q, out_q;
  logic              rd_hit_q, out_valid_q;
  logic [RD_W-1:0]   rd_ext;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_in_range;

  // Unused channels are dropped when a stop is taken in.
  always_comb begin
    color_in = {alpha_in_i, blue_in_i, green_in_i, red_in_i};
    for (int c = 0; c < NUM_CH; c++) begin
      if (c >= CHANNELS) begin
        color_in[c] = '0;
      end
    end
  end

  // Position saturates at one, then maps with rounding half up.
  assign pos_sat = (pos_q > POS_ONE) ? POS_ONE : pos_q;
  assign prod    = PROD_W'(pos_sat) * PROD_W'(TABLE_DEPTH - 1);
  assign idx_sum = prod + PROD_W'(POS_HALF);
  assign idx_d   = idx_sum[16 +: IDX_W];

  // Magnitude and sign of each channel's rise over the segment.
  always_comb begin
    logic [CH_W:0] delta;
    for (int c = 0; c < NUM_CH; c++) begin
      delta       = {1'b0, color_q[c]} - {1'b0, prev_color_q[c]};
      neg_init[c] = delta[CH_W];
      quo_init[c] = delta[CH_W] ? CH_W'(-delta) : delta[CH_W-1:0];
    end
  end

  // The slope is kept as a floor quotient and a remainder in [0, d), so each
  // step adds the quotient and carries one more whenever the remainder wraps.
  always_comb begin
    logic [IDX_W:0] sum;
    logic [IDX_W:0] trial;
    logic           carry;
    logic           ge;
    rem_ok = 1'b1;
    for (int c = 0; c < NUM_CH; c++) begin
      if (neg_q[c] && (rem_q[c] != '0)) begin
        dq_w[c] = ~quo_q[c];
        dr_w[c] = seg_d_q - rem_q[c];
      end else if (neg_q[c]) begin
        dq_w[c] = ~quo_q[c] + CH_W'(1);
        dr_w[c] = rem_q[c];
      end else begin
        dq_w[c] = quo_q[c];
        dr_w[c] = rem_q[c];
      end
      sum    = {1'b0, r_q[c]} + {1'b0, dr_w[c]};
      carry  = (sum >= {1'b0, seg_d_q});
      r_d[c] = carry ? IDX_W'(sum - {1'b0, seg_d_q}) : sum[IDX_W-1:0];
      q_d[c] = q_q[c] + dq_w[c] + CH_W'(carry);

      trial    = {rem_q[c], quo_q[c][CH_W-1]};
      ge       = (trial >= {1'b0, seg_d_q});
      rem_d[c] = ge ? IDX_W'(trial - {1'b0, seg_d_q}) : trial[IDX_W-1:0];
      quo_d[c] = {quo_q[c][CH_W-2:0], ge};

      if (r_q[c] >= seg_d_q) begin
        rem_ok = 1'b0;
      end
    end
  end

  assign rd_ext      = RD_W'(read_index_i);
  assign rd_in_range = rd_ext < RD_W'(TABLE_DEPTH);
  assign rd_addr     = rd_ext[IDX_W-1:0];

  always_comb begin
    status_o.have_prev = have_prev_q;
    status_o.last      = last_q;
    status_o.backward  = idx_q < prev_idx_q;
    status_o.seg_zero  = idx_q == prev_idx_q;
    status_o.div_done  = div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1);
    status_o.walk_done = walk_addr_q == walk_end_q;
    status_o.out_full  = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q  <= 1'b0;
      prev_idx_q   <= '0;
      prev_color_q <= '0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      div_cnt_q    <= '0;
    end else begin
      if (cmd_i.commit) begin
        have_prev_q  <= !last_q;
        prev_idx_q   <= idx_q;
        prev_color_q <= color_q;
      end
      if (cmd_i.walk_step) begin
        valid_q[walk_addr_q] <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.setup) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_latch) begin
      pos_q   <= position_i;
      color_q <= color_in;
      last_q  <= last_stop_i;
    end
    if (cmd_i.calc_idx) begin
      idx_q <= idx_d;
    end
    if (cmd_i.setup) begin
      for (int c = 0; c < NUM_CH; c++) begin
        r_q[c]   <= '0;
        rem_q[c] <= '0;
      end
      case (cmd_i.seg_kind)
        SEG_RAMP: begin
          walk_addr_q <= prev_idx_q;
          walk_end_q  <= idx_q;
          seg_d_q     <= idx_q - prev_idx_q;
          seg_ramp_q  <= 1'b1;
          q_q         <= prev_color_q;
          quo_q       <= quo_init;
          neg_q       <= neg_init;
        end
        SEG_TAIL: begin
          walk_addr_q <= idx_q;
          walk_end_q  <= IDX_W'(TABLE_DEPTH - 1);
          seg_d_q     <= '1;
          seg_ramp_q  <= 1'b0;
          q_q         <= color_q;
          quo_q       <= '0;
          neg_q       <= '0;
        end
        default: begin
          walk_addr_q <= '0;
          walk_end_q  <= idx_q;
          seg_d_q     <= '1;
          seg_ramp_q  <= 1'b0;
          q_q         <= color_q;
          quo_q       <= '0;
          neg_q       <= '0;
        end
      endcase
    end else if (cmd_i.div_step) begin
      quo_q <= quo_d;
      for (int c = 0; c < NUM_CH; c++) begin
        rem_q[c] <= rem_d[c];
      end
    end else if (cmd_i.walk_step) begin
      walk_addr_q <= walk_addr_q + IDX_W'(1);
      q_q         <= q_d;
      for (int c = 0; c < NUM_CH; c++) begin
        r_q[c] <= r_d[c];
      end
    end
    if (cmd_i.rd_issue) begin
      rd_hit_q <= rd_in_range && valid_q[rd_addr];
    end
    if (cmd_i.out_load) begin
      out_q <= rd_hit_q ? rd_data_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_step) begin
      table_mem[walk_addr_q] <= q_q;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= table_mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_color_o = out_q;

  a_walk_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_step && !status_o.walk_done
      |=> walk_addr_q == IDX_W'($past(walk_addr_q) + IDX_W'(1)))
    else $error("table walker did not advance by one entry");

  a_ramp_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_step && status_o.walk_done && seg_ramp_q && (seg_d_q != '0)
      |-> q_q == color_q)
    else $error("ramp did not end on the stop color");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_step && seg_ramp_q && (seg_d_q != '0) |-> rem_ok)
    else $error("slope remainder left its range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !out_valid_q)
    else $error("read result overwrote a pending transaction");

endmodule

`default_nettype wire

[hdl/gradient_color_lut_builder_unit.sv]
// Gradient color table builder: a read fetches its entry when accepted, moves
// it to the output register once that is free, then takes the next input.
// A load latches the stop, maps its index, plans the segment, divides for a
// ramp wider than one entry, walks one entry per step, walks a tail after a
// last stop and commits. Reset clears per-entry valid bits at once, so every
// entry reads zero; no clearing pass. Depends on glb_pkg, glb_ctrl, glb_dpath.
`default_nettype none

module gradient_color_lut_builder_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic [glb_pkg::POS_W-1:0]   position_i,
  input  logic [glb_pkg::CH_W-1:0]    red_in_i,
  input  logic [glb_pkg::CH_W-1:0]    green_in_i,
  input  logic [glb_pkg::CH_W-1:0]    blue_in_i,
  input  logic [glb_pkg::CH_W-1:0]    alpha_in_i,
  input  logic                        last_stop_i,
  input  logic [glb_pkg::RDIDX_W-1:0] read_index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [glb_pkg::CH_W-1:0]    red_out_o,
  output logic [glb_pkg::CH_W-1:0]    green_out_o,
  output logic [glb_pkg::CH_W-1:0]    blue_out_o,
  output logic [glb_pkg::CH_W-1:0]    alpha_out_o
);
  import glb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  color_t     out_color;

  glb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  glb_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .position_i   (position_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .alpha_in_i   (alpha_in_i),
    .last_stop_i  (last_stop_i),
    .read_index_i (read_index_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_color_o  (out_color)
  );

  assign red_out_o   = out_color[0];
  assign green_out_o = out_color[1];
  assign blue_out_o  = out_color[2];
  assign alpha_out_o = out_color[3];

endmodule

`default_nettype wire
